@@ sv/spc_pkg.sv @@
// Shared types, constants and helper functions for the scan polar-to-Cartesian block.
`timescale 1ns / 1ps

package spc_pkg;

  localparam int PTS_MAX = 1024;
  localparam int PTS_AW  = $clog2(PTS_MAX);

  localparam int IDX_W   = 10;
  localparam int RANGE_W = 16;
  localparam int POS_W   = 17;
  localparam int STEP_W  = 14;
  localparam int MAG_W   = 15;
  localparam int ANG_W   = 22;
  localparam int REM_W   = 20;

  localparam logic [STEP_W-1:0] STEP_RESET = 14'd5000;

  localparam logic [ANG_W-1:0] FULL_TURN    = 22'd3600000;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 22'd900000;
  localparam logic [ANG_W-1:0] HALF_TURN    = 22'd1800000;
  localparam logic [ANG_W-1:0] THREE_QUART  = 22'd2700000;

  localparam logic [20:0] RAD_Q40 = 21'd1919010;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam logic [2:0] SINE_LAST = 3'd5;
  localparam logic [2:0] COS_LAST  = 3'd6;

  localparam logic [31:0] RCP_156 = 32'((64'd1 << 32) / 64'd156);
  localparam logic [31:0] RCP_110 = 32'((64'd1 << 32) / 64'd110);
  localparam logic [31:0] RCP_72  = 32'((64'd1 << 32) / 64'd72);
  localparam logic [31:0] RCP_42  = 32'((64'd1 << 32) / 64'd42);
  localparam logic [31:0] RCP_20  = 32'((64'd1 << 32) / 64'd20);
  localparam logic [31:0] RCP_6   = 32'((64'd1 << 32) / 64'd6);
  localparam logic [31:0] RCP_182 = 32'((64'd1 << 32) / 64'd182);
  localparam logic [31:0] RCP_132 = 32'((64'd1 << 32) / 64'd132);
  localparam logic [31:0] RCP_90  = 32'((64'd1 << 32) / 64'd90);
  localparam logic [31:0] RCP_56  = 32'((64'd1 << 32) / 64'd56);
  localparam logic [31:0] RCP_30  = 32'((64'd1 << 32) / 64'd30);
  localparam logic [31:0] RCP_12  = 32'((64'd1 << 32) / 64'd12);
  localparam logic [31:0] RCP_2   = 32'((64'd1 << 32) / 64'd2);

  typedef struct packed {
    logic [7:0]  d;
    logic [31:0] rcp;
  } div_t;

  typedef struct packed {
    logic             x_neg;
    logic [MAG_W-1:0] x_mag;
    logic             y_neg;
    logic [MAG_W-1:0] y_mag;
  } trig_entry_t;

  localparam int ENTRY_W = $bits(trig_entry_t);

  typedef struct packed {
    logic              we;
    logic [PTS_AW-1:0] addr;
    trig_entry_t       data;
  } tbl_wr_t;

  typedef enum logic [3:0] {
    FS_INIT,
    FS_SPLIT,
    FS_RAD,
    FS_SQ,
    FS_MUL,
    FS_RCP,
    FS_CORR,
    FS_SMUL,
    FS_SRND,
    FS_WRITE,
    FS_DONE
  } fill_state_t;

  function automatic div_t series_div(input logic cos_sel, input logic [2:0] k);
    div_t dv;
    case ({cos_sel, k})
      4'b0_000: dv = '{d: 8'd156, rcp: RCP_156};
      4'b0_001: dv = '{d: 8'd110, rcp: RCP_110};
      4'b0_010: dv = '{d: 8'd72,  rcp: RCP_72};
      4'b0_011: dv = '{d: 8'd42,  rcp: RCP_42};
      4'b0_100: dv = '{d: 8'd20,  rcp: RCP_20};
      4'b0_101: dv = '{d: 8'd6,   rcp: RCP_6};
      4'b1_000: dv = '{d: 8'd182, rcp: RCP_182};
      4'b1_001: dv = '{d: 8'd132, rcp: RCP_132};
      4'b1_010: dv = '{d: 8'd90,  rcp: RCP_90};
      4'b1_011: dv = '{d: 8'd56,  rcp: RCP_56};
      4'b1_100: dv = '{d: 8'd30,  rcp: RCP_30};
      4'b1_101: dv = '{d: 8'd12,  rcp: RCP_12};
      4'b1_110: dv = '{d: 8'd2,   rcp: RCP_2};
      default:  dv = '{d: 8'd2,   rcp: RCP_2};
    endcase
    return dv;
  endfunction

  function automatic logic [MAG_W-1:0] to_q15(input logic [31:0] v);
    logic [32:0] sum;
    logic [17:0] r;
    sum = {1'b0, v} + 33'd16384;
    r = sum[32:15];
    return (r > 18'd32767) ? 15'h7fff : r[MAG_W-1:0];
  endfunction

endpackage

@@ sv/spc_ifs.sv @@
// Channel interfaces for configuration, scan point requests and Cartesian results.
`timescale 1ns / 1ps

interface spc_in_if import spc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   point_index;
  logic [RANGE_W-1:0] range_value;

  modport source(output valid, output point_index, output range_value, input ready);
  modport sink(input valid, input point_index, input range_value, output ready);
endinterface

interface spc_out_if import spc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;

  modport source(output valid, output pos_x, output pos_y, input ready);
  modport sink(input valid, input pos_x, input pos_y, output ready);
endinterface

interface spc_cfg_if import spc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] angle_step;

  modport source(output valid, output angle_step, input ready);
  modport sink(input valid, input angle_step, output ready);
endinterface

@@ sv/spc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module spc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/spc_trig_fill.sv @@
// Sequencer that computes the per-index sine and cosine table with one shared multiplier.
`timescale 1ns / 1ps

module spc_trig_fill import spc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [STEP_W-1:0] cfg_step,
  output tbl_wr_t           tbl_wr,
  output logic              tbl_ready
);

  fill_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PTS_AW-1:0] addr_r, addr_nxt;
  logic [ANG_W-1:0]  ang_r, ang_nxt;
  logic [1:0]        quad_r, quad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [30:0]       x_r, x_nxt;
  logic [31:0]       x2_r, x2_nxt;
  logic [30:0]       t_r, t_nxt;
  logic [31:0]       p_r, p_nxt;
  logic [31:0]       qe_r, qe_nxt;
  logic [MAG_W-1:0]  s15_r, s15_nxt;
  logic [2:0]        k_r, k_nxt;
  logic              cos_r, cos_nxt;

  div_t              dv;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [63:0]       prod_rnd;
  logic [31:0]       corr_rem;
  logic [31:0]       corr_q;
  logic [30:0]       t_step;
  logic [MAG_W-1:0]  c15;
  logic [ANG_W:0]    ang_sum;
  logic [ANG_W-1:0]  ang_wrap;
  logic [1:0]        split_quad;
  logic [ANG_W-1:0]  split_rem;
  logic              last_term;
  logic              last_addr;
  trig_entry_t       entry;

  assign dv        = series_div(cos_r, k_r);
  assign last_term = cos_r ? (k_r == COS_LAST) : (k_r == SINE_LAST);
  assign last_addr = (addr_r == PTS_AW'(PTS_MAX - 1));

  always_comb begin
    mul_a = {1'b0, x_r};
    mul_b = {1'b0, x_r};
    case (state_r)
      FS_RAD: begin
        mul_a = {12'b0, rem_r};
        mul_b = {11'b0, RAD_Q40};
      end
      FS_MUL: begin
        mul_a = x2_r;
        mul_b = {1'b0, t_r};
      end
      FS_RCP: begin
        mul_a = p_r;
        mul_b = dv.rcp;
      end
      FS_SMUL: begin
        mul_a = {1'b0, x_r};
        mul_b = {1'b0, t_r};
      end
      default: begin
        mul_a = {1'b0, x_r};
        mul_b = {1'b0, x_r};
      end
    endcase
  end

  assign prod     = {32'b0, mul_a} * {32'b0, mul_b};
  assign prod_rnd = prod + 64'd512;
  assign corr_rem = p_r - 32'(qe_r * {24'b0, dv.d});
  assign corr_q   = qe_r + {31'b0, (corr_rem >= {24'b0, dv.d})};
  assign t_step   = (corr_q > {1'b0, ONE_Q30}) ? 31'd0 : 31'({1'b0, ONE_Q30} - corr_q);
  assign c15      = to_q15({1'b0, t_r});
  assign ang_sum  = {1'b0, ang_r} + {{(ANG_W + 1 - STEP_W){1'b0}}, step_r};
  assign ang_wrap = (ang_sum >= {1'b0, FULL_TURN}) ? ANG_W'(ang_sum - {1'b0, FULL_TURN})
                                                   : ang_sum[ANG_W-1:0];

  always_comb begin
    if (ang_r >= THREE_QUART) begin
      split_quad = 2'd3;
      split_rem  = ang_r - THREE_QUART;
    end else if (ang_r >= HALF_TURN) begin
      split_quad = 2'd2;
      split_rem  = ang_r - HALF_TURN;
    end else if (ang_r >= QUARTER_TURN) begin
      split_quad = 2'd1;
      split_rem  = ang_r - QUARTER_TURN;
    end else begin
      split_quad = 2'd0;
      split_rem  = ang_r;
    end
  end

  always_comb begin
    case (quad_r)
      2'd0: entry = '{x_neg: 1'b0, x_mag: s15_r, y_neg: 1'b1, y_mag: c15};
      2'd1: entry = '{x_neg: 1'b0, x_mag: c15,   y_neg: 1'b0, y_mag: s15_r};
      2'd2: entry = '{x_neg: 1'b1, x_mag: s15_r, y_neg: 1'b0, y_mag: c15};
      default: entry = '{x_neg: 1'b1, x_mag: c15, y_neg: 1'b1, y_mag: s15_r};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_INIT:  state_nxt = FS_SPLIT;
      FS_SPLIT: state_nxt = FS_RAD;
      FS_RAD:   state_nxt = FS_SQ;
      FS_SQ:    state_nxt = FS_MUL;
      FS_MUL:   state_nxt = FS_RCP;
      FS_RCP:   state_nxt = FS_CORR;
      FS_CORR: begin
        if (last_term) begin
          state_nxt = cos_r ? FS_WRITE : FS_SMUL;
        end else begin
          state_nxt = FS_MUL;
        end
      end
      FS_SMUL:  state_nxt = FS_SRND;
      FS_SRND:  state_nxt = FS_MUL;
      FS_WRITE: state_nxt = last_addr ? FS_DONE : FS_SPLIT;
      FS_DONE:  state_nxt = FS_DONE;
      default:  state_nxt = FS_INIT;
    endcase
    if (cfg_we) begin
      state_nxt = FS_INIT;
    end
  end

  always_comb begin
    step_nxt     = cfg_we ? cfg_step : step_r;
    addr_nxt     = addr_r;
    ang_nxt      = ang_r;
    quad_nxt     = quad_r;
    rem_nxt      = rem_r;
    x_nxt        = x_r;
    x2_nxt       = x2_r;
    t_nxt        = t_r;
    p_nxt        = p_r;
    qe_nxt       = qe_r;
    s15_nxt      = s15_r;
    k_nxt        = k_r;
    cos_nxt      = cos_r;
    tbl_wr.we    = 1'b0;
    tbl_wr.addr  = addr_r;
    tbl_wr.data  = entry;
    tbl_ready    = 1'b0;
    case (state_r)
      FS_INIT: begin
        addr_nxt = '0;
        ang_nxt  = '0;
      end
      FS_SPLIT: begin
        quad_nxt = split_quad;
        rem_nxt  = split_rem[REM_W-1:0];
        t_nxt    = ONE_Q30;
        k_nxt    = 3'd0;
        cos_nxt  = 1'b0;
      end
      FS_RAD: begin
        x_nxt = prod_rnd[40:10];
      end
      FS_SQ: begin
        x2_nxt = prod[61:30];
      end
      FS_MUL: begin
        p_nxt = prod[61:30];
      end
      FS_RCP: begin
        qe_nxt = prod[63:32];
      end
      FS_CORR: begin
        t_nxt = t_step;
        k_nxt = k_r + 3'd1;
      end
      FS_SMUL: begin
        p_nxt = prod[61:30];
      end
      FS_SRND: begin
        s15_nxt = to_q15(p_r);
        t_nxt   = ONE_Q30;
        k_nxt   = 3'd0;
        cos_nxt = 1'b1;
      end
      FS_WRITE: begin
        tbl_wr.we = 1'b1;
        addr_nxt  = addr_r + PTS_AW'(1);
        ang_nxt   = ang_wrap;
      end
      FS_DONE: begin
        tbl_ready = 1'b1;
      end
      default: begin
        tbl_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_INIT;
      step_r  <= STEP_RESET;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
    addr_r <= addr_nxt;
    ang_r  <= ang_nxt;
    quad_r <= quad_nxt;
    rem_r  <= rem_nxt;
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    t_r    <= t_nxt;
    p_r    <= p_nxt;
    qe_r   <= qe_nxt;
    s15_r  <= s15_nxt;
    k_r    <= k_nxt;
    cos_r  <= cos_nxt;
  end

endmodule

@@ sv/scan_polar_to_cartesian_top.sv @@
// Top level of the scan point polar-to-Cartesian converter.
//
// The cfg_chan channel writes the angular step in 1/10000 degree; it is always ready.
// Each write, and every reset, starts a rebuild of a 1024-entry sine/cosine table that
// holds the signed Q1.15 factors for every point index. The rebuild runs on one shared
// multiplier, and in_chan.ready stays low until it ends.
// Once the table is ready, in_chan takes one scan point per cycle while no stall holds
// the pipeline. Each request reads its table entry, multiplies the range by the two
// factors and rounds. It passes through the range register, the product register and
// the output register before its result is valid on out_chan, and one result per cycle
// leaves the block when the receiver keeps out_chan.ready high.
// The three result stages advance independently, so a request is still taken while a
// finished result waits, as long as a stage further down is empty. When out_chan.ready
// stays low the result holds and the pipeline fills, after which in_chan.ready drops
// until the receiver takes a result.
// Reset clears the pipeline, restores the step to 5000 and starts the table rebuild.
`timescale 1ns / 1ps

module scan_polar_to_cartesian_top import spc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  spc_cfg_if.sink   cfg_chan,
  spc_in_if.sink    in_chan,
  spc_out_if.source out_chan
);

  tbl_wr_t            tbl_wr;
  logic               tbl_ready;
  logic [ENTRY_W-1:0] ram_rdata;
  trig_entry_t        ent;

  logic               en_out, en2, en1;
  logic               in_acc;

  logic               s1_v_r, s1_v_nxt;
  logic [RANGE_W-1:0] range_s1_r, range_s1_nxt;
  logic               s2_v_r, s2_v_nxt;
  logic [30:0]        prod_x_r, prod_x_nxt;
  logic [30:0]        prod_y_r, prod_y_nxt;
  logic               neg_x_r, neg_x_nxt;
  logic               neg_y_r, neg_y_nxt;
  logic               out_v_r, out_v_nxt;
  logic [POS_W-1:0]   pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]   pos_y_r, pos_y_nxt;
  logic [31:0]        rnd_x, rnd_y;
  logic [POS_W-1:0]   mag_x, mag_y;

  assign cfg_chan.ready = 1'b1;

  spc_trig_fill u_fill (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_chan.valid),
    .cfg_step  (cfg_chan.angle_step),
    .tbl_wr    (tbl_wr),
    .tbl_ready (tbl_ready)
  );

  spc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PTS_MAX)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_wr.we),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .re    (en1),
    .raddr (in_chan.point_index[PTS_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ent    = trig_entry_t'(ram_rdata);
  assign en_out = !out_v_r || out_chan.ready;
  assign en2    = !s2_v_r || en_out;
  assign en1    = !s1_v_r || en2;

  assign in_chan.ready = tbl_ready && en1;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign rnd_x = {1'b0, prod_x_r} + 32'd16384;
  assign rnd_y = {1'b0, prod_y_r} + 32'd16384;
  assign mag_x = rnd_x[31:15];
  assign mag_y = rnd_y[31:15];

  always_comb begin
    s1_v_nxt     = s1_v_r;
    range_s1_nxt = range_s1_r;
    s2_v_nxt     = s2_v_r;
    prod_x_nxt   = prod_x_r;
    prod_y_nxt   = prod_y_r;
    neg_x_nxt    = neg_x_r;
    neg_y_nxt    = neg_y_r;
    out_v_nxt    = out_v_r;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    if (en1) begin
      s1_v_nxt     = in_acc;
      range_s1_nxt = in_chan.range_value;
    end
    if (en2) begin
      s2_v_nxt   = s1_v_r;
      prod_x_nxt = {15'b0, range_s1_r} * {16'b0, ent.x_mag};
      prod_y_nxt = {15'b0, range_s1_r} * {16'b0, ent.y_mag};
      neg_x_nxt  = ent.x_neg;
      neg_y_nxt  = ent.y_neg;
    end
    if (en_out) begin
      out_v_nxt = s2_v_r;
      pos_x_nxt = neg_x_r ? POS_W'(-mag_x) : mag_x;
      pos_y_nxt = neg_y_r ? POS_W'(-mag_y) : mag_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
    range_s1_r <= range_s1_nxt;
    prod_x_r   <= prod_x_nxt;
    prod_y_r   <= prod_y_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.pos_x = $signed(pos_x_r);
  assign out_chan.pos_y = $signed(pos_y_r);

endmodule

@@ sv/spc_checker.sv @@
// Port-level checker for the polar-to-Cartesian converter and its bind to the top level.
`timescale 1ns / 1ps

module spc_checker import spc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic signed [POS_W-1:0] pos_x,
  input logic signed [POS_W-1:0] pos_y
);

  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r + {2'b0, (in_valid && in_ready)} - {2'b0, (out_valid && out_ready)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("Input was ready right after a step write.");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd3)
    else $error("More requests in flight than pipeline stages.");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("Result shown with no request in flight.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y))
    else $error("Stalled result changed or was dropped.");

endmodule

bind scan_polar_to_cartesian_top spc_checker u_spc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .cfg_valid (cfg_chan.valid),
  .cfg_ready (cfg_chan.ready),
  .pos_x     (out_chan.pos_x),
  .pos_y     (out_chan.pos_y)
);
